// File: rtl/qte_pkg.sv
package qte_pkg;

  // Pitch path widths are fixed by the 2^30 scaling of the pitch term.
  localparam int PN_W   = 30;
  localparam int PS_W   = 32;
  localparam int RAD_W  = 61;
  localparam int ROOT_W = 31;
  localparam int SQRT_STAGES = 31;
  localparam logic [RAD_W-1:0] RAD_ONE = 61'h1000_0000_0000_0000;

  // CORDIC datapath: magnitudes enter below 2^31 and grow by the gain.
  localparam int NORM_W = 31;
  localparam int XW = 36;
  localparam int ZW = 34;
  localparam int FRAC_BITS = 24;
  localparam logic signed [ZW-1:0] DEG45  = 34'sd754974720;
  localparam logic signed [ZW-1:0] DEG90  = 34'sd1509949440;
  localparam logic signed [ZW-1:0] DEG180 = 34'sd3019898880;
  localparam logic signed [ZW-1:0] Z_MIN  = 34'sd1;
  localparam logic signed [ZW-1:0] Z_MAX  = 34'sd754974719;

  localparam int ROLL_W  = 9;
  localparam int PITCH_W = 8;
  localparam int YAW_W   = 9;
  localparam int DEG_W   = 9;

  typedef struct packed {
    logic s_neg;
    logic c_neg;
    logic s_zero;
    logic c_zero;
    logic equal;
    logic lt;
  } oct_flags_t;

  // Arctangent of 2^-i in degrees, 24 fraction bits.
  function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0:  a = 34'sd754974720;
      5'd1:  a = 34'sd445687602;
      5'd2:  a = 34'sd235489088;
      5'd3:  a = 34'sd119537938;
      5'd4:  a = 34'sd60000934;
      5'd5:  a = 34'sd30029717;
      5'd6:  a = 34'sd15018523;
      5'd7:  a = 34'sd7509720;
      5'd8:  a = 34'sd3754917;
      5'd9:  a = 34'sd1877466;
      5'd10: a = 34'sd938734;
      5'd11: a = 34'sd469367;
      5'd12: a = 34'sd234684;
      5'd13: a = 34'sd117342;
      5'd14: a = 34'sd58671;
      5'd15: a = 34'sd29335;
      5'd16: a = 34'sd14668;
      5'd17: a = 34'sd7334;
      5'd18: a = 34'sd3667;
      5'd19: a = 34'sd1833;
      5'd20: a = 34'sd917;
      5'd21: a = 34'sd458;
      5'd22: a = 34'sd229;
      5'd23: a = 34'sd115;
      5'd24: a = 34'sd57;
      5'd25: a = 34'sd29;
      5'd26: a = 34'sd14;
      5'd27: a = 34'sd7;
      5'd28: a = 34'sd4;
      5'd29: a = 34'sd2;
      5'd30: a = 34'sd1;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/qte_front.sv
module qte_front #(
  parameter int W = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [W-1:0]               in_w,
  input  logic [W-1:0]               in_x,
  input  logic [W-1:0]               in_y,
  input  logic [W-1:0]               in_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [4*(2*(W>30?30:W)+1)-1:0] out_ry,
  output logic signed [qte_pkg::PS_W-1:0] out_pitch_s,
  output logic                       out_sat,
  output logic [qte_pkg::RAD_W-1:0]  out_rad
);

  localparam int E  = (W > 30) ? 30 : W;
  localparam int SW = 2 * E + 1;
  localparam int SH = 2 * E - 33;
  localparam int RSH = (SH > 0) ? SH : 0;
  localparam int NSH = (SH < 0) ? -SH : 0;
  localparam int D = 6;
  localparam logic [SW-1:0] UNIT = SW'(1) << (2 * E - 3);

  logic [D-1:0] v_r;
  logic [D-1:0] vin;
  logic [D:0]   rdy;

  assign vin = {v_r[D-2:0], in_valid};
  assign rdy[D] = out_ready;
  assign in_ready = rdy[0];
  assign out_valid = v_r[D-1];

  for (genvar d = 0; d < D; d++) begin : g_vld
    assign rdy[d] = !v_r[d] || rdy[d+1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[d] <= 1'b0;
      end else if (rdy[d]) begin
        v_r[d] <= vin[d];
      end
    end
  end

  // Stage 0: keep the top bits of each component.
  logic signed [E-1:0] cw_r, cx_r, cy_r, cz_r;
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      cw_r <= in_w[W-1 -: E];
      cx_r <= in_x[W-1 -: E];
      cy_r <= in_y[W-1 -: E];
      cz_r <= in_z[W-1 -: E];
    end
  end

  // Stage 1: all pairwise products and the squares of x, y and z.
  logic signed [2*E-1:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      wx_r <= cw_r * cx_r;
      yz_r <= cy_r * cz_r;
      xx_r <= cx_r * cx_r;
      yy_r <= cy_r * cy_r;
      wz_r <= cw_r * cz_r;
      xy_r <= cx_r * cy_r;
      zz_r <= cz_r * cz_r;
      wy_r <= cw_r * cy_r;
      zx_r <= cz_r * cx_r;
    end
  end

  // Stage 2: sine and cosine terms in units of 1/UNIT.
  logic signed [SW-1:0] roll_s_nxt, roll_c_nxt, yaw_s_nxt, yaw_c_nxt, p_nxt, p_r;
  logic [4*SW-1:0] ry2_r, ry3_r, ry4_r, ry5_r;
  always_comb begin
    roll_s_nxt = SW'(wx_r) + SW'(yz_r);
    roll_c_nxt = $signed(UNIT) - SW'(xx_r) - SW'(yy_r);
    yaw_s_nxt  = SW'(wz_r) + SW'(xy_r);
    yaw_c_nxt  = $signed(UNIT) - SW'(yy_r) - SW'(zz_r);
    p_nxt      = SW'(wy_r) - SW'(zx_r);
  end
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      ry2_r <= {yaw_c_nxt, yaw_s_nxt, roll_c_nxt, roll_s_nxt};
      p_r   <= p_nxt;
    end
  end

  // Stage 3: pitch magnitude, saturation and scaling to 2^30.
  logic [SW-1:0] ap_nxt;
  logic [qte_pkg::PN_W+SW-1:0] ap_w;
  logic sat_nxt;
  logic [qte_pkg::PN_W-1:0] pn_nxt, pn_r;
  logic neg_r, sat3_r, sat4_r, sat5_r;
  always_comb begin
    ap_nxt  = p_r[SW-1] ? SW'(-p_r) : SW'(p_r);
    sat_nxt = (ap_nxt >= UNIT);
    ap_w    = (qte_pkg::PN_W + SW)'(ap_nxt);
    pn_nxt  = sat_nxt ? '0 : qte_pkg::PN_W'((ap_w >> RSH) << NSH);
  end
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      ry3_r  <= ry2_r;
      pn_r   <= pn_nxt;
      neg_r  <= p_r[SW-1];
      sat3_r <= sat_nxt;
    end
  end

  // Stage 4: square of the scaled term and the signed sine for pitch.
  logic [2*qte_pkg::PN_W-1:0] pn_sq_r;
  logic signed [qte_pkg::PS_W-1:0] ps_nxt, ps4_r, ps5_r;
  always_comb begin
    if (sat3_r) begin
      ps_nxt = neg_r ? -32'sd1 : 32'sd1;
    end else begin
      ps_nxt = neg_r ? -$signed(qte_pkg::PS_W'(pn_r)) : $signed(qte_pkg::PS_W'(pn_r));
    end
  end
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      ry4_r   <= ry3_r;
      pn_sq_r <= pn_r * pn_r;
      ps4_r   <= ps_nxt;
      sat4_r  <= sat3_r;
    end
  end

  // Stage 5: radicand for the cosine of pitch.
  logic [qte_pkg::RAD_W-1:0] rad_r;
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      ry5_r  <= ry4_r;
      rad_r  <= qte_pkg::RAD_ONE - qte_pkg::RAD_W'(pn_sq_r);
      ps5_r  <= ps4_r;
      sat5_r <= sat4_r;
    end
  end

  assign out_ry      = ry5_r;
  assign out_pitch_s = ps5_r;
  assign out_sat     = sat5_r;
  assign out_rad     = rad_r;

endmodule

// File: rtl/qte_sqrt.sv
module qte_sqrt #(
  parameter int PAY_W = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [qte_pkg::RAD_W-1:0]     in_rad,
  input  logic [PAY_W-1:0]              in_pay,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qte_pkg::ROOT_W-1:0]    out_root,
  output logic [PAY_W-1:0]              out_pay
);

  localparam int D  = qte_pkg::SQRT_STAGES;
  localparam int RW = qte_pkg::RAD_W + 1;

  logic [D-1:0] v_r;
  logic [D-1:0] vin;
  logic [D:0]   rdy;

  assign vin = {v_r[D-2:0], in_valid};
  assign rdy[D] = out_ready;
  assign in_ready = rdy[0];
  assign out_valid = v_r[D-1];

  logic [qte_pkg::RAD_W-1:0] rem_r [D];
  logic [RW-1:0]             root_r [D];
  logic [PAY_W-1:0]          pay_r [D];

  // One root bit per stage, most significant first.
  for (genvar d = 0; d < D; d++) begin : g_stg
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (D - 1 - d));
    logic [qte_pkg::RAD_W-1:0] rem_in;
    logic [RW-1:0] root_in, trial;
    logic [PAY_W-1:0] pay_in;

    if (d == 0) begin : g_first
      assign rem_in  = in_rad;
      assign root_in = '0;
      assign pay_in  = in_pay;
    end else begin : g_next
      assign rem_in  = rem_r[d-1];
      assign root_in = root_r[d-1];
      assign pay_in  = pay_r[d-1];
    end

    assign rdy[d] = !v_r[d] || rdy[d+1];
    assign trial  = root_in + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[d] <= 1'b0;
      end else if (rdy[d]) begin
        v_r[d] <= vin[d];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[d]) begin
        pay_r[d] <= pay_in;
        if (RW'(rem_in) >= trial) begin
          rem_r[d]  <= qte_pkg::RAD_W'(RW'(rem_in) - trial);
          root_r[d] <= (root_in >> 1) + BIT;
        end else begin
          rem_r[d]  <= rem_in;
          root_r[d] <= root_in >> 1;
        end
      end
    end
  end

  assign out_root = qte_pkg::ROOT_W'(root_r[D-1]);
  assign out_pay  = pay_r[D-1];

endmodule

// File: rtl/qte_atan2.sv
module qte_atan2 #(
  parameter int SC_W   = 33,
  parameter int STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SC_W-1:0]              in_s,
  input  logic signed [SC_W-1:0]              in_c,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qte_pkg::DEG_W-1:0]    out_deg
);

  localparam int N   = (STAGES > 32) ? 32 : STAGES;
  localparam int D   = N + 5;
  localparam int K_W = $clog2(SC_W + 1);
  localparam int XW  = qte_pkg::XW;
  localparam int ZW  = qte_pkg::ZW;

  logic [D-1:0] v_r;
  logic [D-1:0] vin;
  logic [D:0]   rdy;

  assign vin = {v_r[D-2:0], in_valid};
  assign rdy[D] = out_ready;
  assign in_ready = rdy[0];
  assign out_valid = v_r[D-1];

  for (genvar d = 0; d < D; d++) begin : g_vld
    assign rdy[d] = !v_r[d] || rdy[d+1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[d] <= 1'b0;
      end else if (rdy[d]) begin
        v_r[d] <= vin[d];
      end
    end
  end

  // Octant flags travel alongside the data up to the final stage.
  qte_pkg::oct_flags_t flag_r [D-1];
  for (genvar d = 1; d < D - 1; d++) begin : g_flag
    always_ff @(posedge clk) begin
      if (rdy[d]) begin
        flag_r[d] <= flag_r[d-1];
      end
    end
  end

  // Stage A: magnitudes and octant selection.
  logic [SC_W-1:0] as_nxt, ac_nxt, big_a_r, small_a_r;
  qte_pkg::oct_flags_t flag_nxt;
  always_comb begin
    as_nxt = in_s[SC_W-1] ? SC_W'(-in_s) : SC_W'(in_s);
    ac_nxt = in_c[SC_W-1] ? SC_W'(-in_c) : SC_W'(in_c);
    flag_nxt.s_neg  = in_s[SC_W-1];
    flag_nxt.c_neg  = in_c[SC_W-1];
    flag_nxt.s_zero = (as_nxt == '0);
    flag_nxt.c_zero = (ac_nxt == '0);
    flag_nxt.equal  = (as_nxt == ac_nxt);
    flag_nxt.lt     = (as_nxt < ac_nxt);
  end
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      flag_r[0] <= flag_nxt;
      big_a_r   <= flag_nxt.lt ? ac_nxt : as_nxt;
      small_a_r <= flag_nxt.lt ? as_nxt : ac_nxt;
    end
  end

  // Stage B: shift that brings the larger magnitude below 2^31.
  logic [K_W-1:0] k_nxt, k_r;
  logic [SC_W-1:0] big_b_r, small_b_r;
  always_comb begin
    k_nxt = '0;
    for (int i = qte_pkg::NORM_W; i < SC_W; i++) begin
      if (big_a_r[i]) begin
        k_nxt = K_W'(i - qte_pkg::NORM_W + 1);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      k_r       <= k_nxt;
      big_b_r   <= big_a_r;
      small_b_r <= small_a_r;
    end
  end

  // Stage C and the CORDIC rotations.
  logic signed [XW-1:0] x_r [N+1];
  logic signed [XW-1:0] y_r [N+1];
  logic signed [ZW-1:0] z_r [N+1];
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      x_r[0] <= XW'(big_b_r >> k_r);
      y_r[0] <= XW'(small_b_r >> k_r);
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rdy[3+i]) begin
        if (!y_r[i][XW-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + qte_pkg::atan_q24(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - qte_pkg::atan_q24(5'(i));
        end
      end
    end
  end

  // Stage F1: clamp and fold the octant into the first quadrant.
  logic signed [ZW-1:0] zc_nxt, alpha_nxt, alpha_r;
  qte_pkg::oct_flags_t fl1;
  assign fl1 = flag_r[N+2];
  always_comb begin
    if (z_r[N] < qte_pkg::Z_MIN) begin
      zc_nxt = qte_pkg::Z_MIN;
    end else if (z_r[N] > qte_pkg::Z_MAX) begin
      zc_nxt = qte_pkg::Z_MAX;
    end else begin
      zc_nxt = z_r[N];
    end
    if (fl1.s_zero) begin
      alpha_nxt = '0;
    end else if (fl1.c_zero) begin
      alpha_nxt = qte_pkg::DEG90;
    end else if (fl1.equal) begin
      alpha_nxt = qte_pkg::DEG45;
    end else if (fl1.lt) begin
      alpha_nxt = zc_nxt;
    end else begin
      alpha_nxt = qte_pkg::DEG90 - zc_nxt;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy[N+3]) begin
      alpha_r <= alpha_nxt;
    end
  end

  // Stage F2: quadrant, truncation to whole degrees and sign.
  logic signed [ZW-1:0] mag_nxt;
  logic signed [qte_pkg::DEG_W-1:0] deg_nxt, deg_r;
  qte_pkg::oct_flags_t fl2;
  assign fl2 = flag_r[N+3];
  always_comb begin
    mag_nxt = fl2.c_neg ? qte_pkg::DEG180 - alpha_r : alpha_r;
    deg_nxt = qte_pkg::DEG_W'(mag_nxt >>> qte_pkg::FRAC_BITS);
    if (fl2.s_neg) begin
      deg_nxt = -deg_nxt;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy[N+4]) begin
      deg_r <= deg_nxt;
    end
  end

  assign out_deg = deg_r;

endmodule

// File: rtl/quaternion_to_euler_degrees_top.sv
// Quaternion to Euler angles (ZYX) in whole degrees.
//
// Input channel: one word per quaternion on in_tdata, components w, x, y, z
// as signed fractions with COMPONENT_WIDTH bits each. Result channel: one
// word per input on out_tdata holding roll, pitch and yaw, each truncated
// towards zero; pitch saturates at plus or minus 90 degrees.
//
// The block is a deep pipeline and takes one word in every cycle unless a
// stall at out_tready has filled it. It is built from stages of products and
// sums, a 31-stage square-root pipeline for the cosine of pitch, then three
// parallel arctangent pipelines of CORDIC_STAGES + 5 stages each.
//
// Every stage carries its own valid bit and is loaded whenever it is empty or
// the stage after it moves, so a stall at out_tready backs up only as far as
// the filled stages reach; empty stages still take new words. Nothing is lost
// or repeated. A synchronous reset (rst_n low) empties the pipeline; no
// result is presented until new words arrive.
module quaternion_to_euler_degrees_top #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // quat_w, quat_x, quat_y, quat_z from the lowest bit up, zero padded to bytes
  input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // roll_deg [8:0], pitch_deg [16:9], yaw_deg [25:17], zero padding above
  output logic [31:0] out_tdata
);

  localparam int W     = COMPONENT_WIDTH;
  localparam int E     = (W > 30) ? 30 : W;
  localparam int SW    = 2 * E + 1;
  localparam int SC_W  = (SW > qte_pkg::PS_W) ? SW : qte_pkg::PS_W;
  localparam int PAY_W = 4 * SW + qte_pkg::PS_W + 1;

  // Front end: products, sine and cosine terms, pitch radicand.
  logic fr_valid, fr_ready, fr_sat;
  logic [4*SW-1:0] fr_ry;
  logic signed [qte_pkg::PS_W-1:0] fr_ps;
  logic [qte_pkg::RAD_W-1:0] fr_rad;

  qte_front #(.W(W)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_w        (in_tdata[0*W +: W]),
    .in_x        (in_tdata[1*W +: W]),
    .in_y        (in_tdata[2*W +: W]),
    .in_z        (in_tdata[3*W +: W]),
    .out_valid   (fr_valid),
    .out_ready   (fr_ready),
    .out_ry      (fr_ry),
    .out_pitch_s (fr_ps),
    .out_sat     (fr_sat),
    .out_rad     (fr_rad)
  );

  // Square root; the roll and yaw terms, pitch sine and saturation flag ride along as payload.
  logic sq_valid, sq_ready;
  logic [qte_pkg::ROOT_W-1:0] sq_root;
  logic [PAY_W-1:0] sq_pay;

  qte_sqrt #(.PAY_W(PAY_W)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_rad    (fr_rad),
    .in_pay    ({fr_sat, fr_ps, fr_ry}),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_root  (sq_root),
    .out_pay   (sq_pay)
  );

  logic signed [SW-1:0] roll_s, roll_c, yaw_s, yaw_c;
  logic signed [qte_pkg::PS_W-1:0] pitch_s;
  logic pitch_sat;
  logic signed [SC_W-1:0] pitch_c;

  assign roll_s    = sq_pay[0*SW +: SW];
  assign roll_c    = sq_pay[1*SW +: SW];
  assign yaw_s     = sq_pay[2*SW +: SW];
  assign yaw_c     = sq_pay[3*SW +: SW];
  assign pitch_s   = sq_pay[4*SW +: qte_pkg::PS_W];
  assign pitch_sat = sq_pay[PAY_W-1];
  // A saturated pitch term arrives as a signed sine of one LSB with zero cosine: +-90.
  assign pitch_c   = pitch_sat ? '0 : SC_W'(sq_root);

  // Three arctangent lanes run in lock step.
  logic r_ready, p_ready, y_ready, r_valid, p_valid, y_valid, lane_go;
  logic signed [qte_pkg::DEG_W-1:0] roll_deg, pitch_wide, yaw_deg;
  logic signed [qte_pkg::PITCH_W-1:0] pitch_deg;

  assign sq_ready = r_ready && p_ready && y_ready;
  assign lane_go  = sq_valid && sq_ready;

  qte_atan2 #(.SC_W(SC_W), .STAGES(CORDIC_STAGES)) u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lane_go),
    .in_ready  (r_ready),
    .in_s      (SC_W'(roll_s)),
    .in_c      (SC_W'(roll_c)),
    .out_valid (r_valid),
    .out_ready (out_tready),
    .out_deg   (roll_deg)
  );

  qte_atan2 #(.SC_W(SC_W), .STAGES(CORDIC_STAGES)) u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lane_go),
    .in_ready  (p_ready),
    .in_s      (SC_W'(pitch_s)),
    .in_c      (pitch_c),
    .out_valid (p_valid),
    .out_ready (out_tready),
    .out_deg   (pitch_wide)
  );

  qte_atan2 #(.SC_W(SC_W), .STAGES(CORDIC_STAGES)) u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lane_go),
    .in_ready  (y_ready),
    .in_s      (SC_W'(yaw_s)),
    .in_c      (SC_W'(yaw_c)),
    .out_valid (y_valid),
    .out_ready (out_tready),
    .out_deg   (yaw_deg)
  );

  assign pitch_deg  = qte_pkg::PITCH_W'(pitch_wide);
  assign out_tvalid = r_valid;
  assign out_tdata  = {6'b0, yaw_deg, pitch_deg, roll_deg};

  // The lanes must never drift apart.
  a_lane_valid_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (r_valid == p_valid) && (r_valid == y_valid))
    else $error("arctangent lanes out of step on valid");

  a_lane_ready_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (r_ready == p_ready) && (r_ready == y_ready))
    else $error("arctangent lanes out of step on ready");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pitch_wide <= 9'sd90) && (pitch_wide >= -9'sd90))
    else $error("pitch outside plus or minus 90 degrees");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (roll_deg <= 9'sd180) && (roll_deg >= -9'sd180))
    else $error("roll outside plus or minus 180 degrees");

endmodule
